// ===== hw/rtl/doubly_linked_list_engine_defines.svh =====
// Assertion helpers shared by the checker.
`ifndef DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH
`define DOUBLY_LINKED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DLLE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dll check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DLLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dll check failed");

`endif

// ===== hw/rtl/dll_pkg.sv =====
`default_nettype none

package dll_pkg;

    localparam int CAPACITY   = 1024;
    localparam int SLOT_COUNT = CAPACITY + 2;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int FILL_W     = $clog2(SLOT_COUNT + 1);
    localparam int HANDLE_W   = 11;
    localparam int VALUE_W    = 32;

    typedef logic [SLOT_W-1:0] slot_t;

    localparam slot_t HEAD_SLOT  = slot_t'(0);
    localparam slot_t TAIL_SLOT  = slot_t'(1);
    localparam slot_t FIRST_SLOT = slot_t'(2);

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_DELETE     = 3'd2,
        MODE_INS_LEFT   = 3'd3,
        MODE_INS_RIGHT  = 3'd4,
        MODE_WALK       = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_UNASSIGNED = 2'd2,
        ST_DELETED    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_WR_NEW,
        S_WR_LINK,
        S_VALUE
    } state_t;

    // One write port per field array of the node store.
    typedef struct packed {
        logic               value_we;
        slot_t              value_addr;
        logic [VALUE_W-1:0] value_data;
        logic               left_we;
        slot_t              left_addr;
        slot_t              left_data;
        logic               right_we;
        slot_t              right_addr;
        slot_t              right_data;
        logic               live_we;
        slot_t              live_addr;
        logic               live_data;
    } store_wr_t;

    // Registered read of all fields of one slot.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        slot_t              left;
        slot_t              right;
        logic               live;
    } store_rd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dll_store.sv =====
`default_nettype none

// Node store: per-field arrays sharing one read address, registered read.
module dll_store (
    input  wire logic               clk,
    input  wire dll_pkg::store_wr_t wr,
    input  wire dll_pkg::slot_t     rd_addr,
    output dll_pkg::store_rd_t      rd_data
);

    logic [dll_pkg::VALUE_W-1:0] value_mem [dll_pkg::SLOT_COUNT];
    dll_pkg::slot_t              left_mem  [dll_pkg::SLOT_COUNT];
    dll_pkg::slot_t              right_mem [dll_pkg::SLOT_COUNT];
    logic                        live_mem  [dll_pkg::SLOT_COUNT];

    dll_pkg::store_rd_t rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr.value_we)
        begin
            value_mem[wr.value_addr] <= wr.value_data;
        end
        if (wr.left_we)
        begin
            left_mem[wr.left_addr] <= wr.left_data;
        end
        if (wr.right_we)
        begin
            right_mem[wr.right_addr] <= wr.right_data;
        end
        if (wr.live_we)
        begin
            live_mem[wr.live_addr] <= wr.live_data;
        end
        rd_reg.value <= value_mem[rd_addr];
        rd_reg.left  <= left_mem[rd_addr];
        rd_reg.right <= right_mem[rd_addr];
        rd_reg.live  <= live_mem[rd_addr];
    end

    assign rd_data = rd_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/dll_ctrl.sv =====
`default_nettype none

// Sequencer: handle checks, link read, two write passes per insert.
module dll_ctrl (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [2:0]                         mode,
    input  wire logic [dll_pkg::HANDLE_W-1:0]       handle,
    input  wire logic signed [dll_pkg::VALUE_W-1:0] value,
    output logic                                    done,
    output logic [dll_pkg::HANDLE_W-1:0]            node_handle,
    output logic signed [dll_pkg::VALUE_W-1:0]      node_value,
    output logic                                    at_end,
    output logic [1:0]                              status,
    output dll_pkg::store_wr_t                      store_wr,
    output dll_pkg::slot_t                          rd_addr,
    input  wire dll_pkg::store_rd_t                 store_rd
);

    dll_pkg::state_t state_reg, state_next;
    logic [2:0]      mode_reg, mode_next;
    dll_pkg::slot_t  slot_reg, slot_next;
    logic signed [dll_pkg::VALUE_W-1:0] value_reg, value_next;
    dll_pkg::slot_t  k_reg, k_next;
    dll_pkg::slot_t  nx_reg, nx_next;
    dll_pkg::slot_t  head_right_reg, head_right_next;
    dll_pkg::slot_t  tail_left_reg, tail_left_next;
    logic [dll_pkg::FILL_W-1:0] next_free_reg, next_free_next;

    logic                                done_reg;
    logic [dll_pkg::HANDLE_W-1:0]        node_handle_reg;
    logic signed [dll_pkg::VALUE_W-1:0]  node_value_reg;
    logic                                at_end_reg;
    logic [1:0]                          status_reg;

    logic                               fin;
    logic [dll_pkg::HANDLE_W-1:0]       fin_handle;
    logic [dll_pkg::VALUE_W-1:0]        fin_value;
    logic                               fin_end;
    dll_pkg::status_t                   fin_status;

    dll_pkg::slot_t slot_in;
    dll_pkg::slot_t new_slot;
    logic           full;
    logic           bad_handle;

    function automatic logic walk_stop(input dll_pkg::slot_t s);
        walk_stop = (s < dll_pkg::FIRST_SLOT) || (32'(s) >= 32'(dll_pkg::SLOT_COUNT));
    endfunction

    assign slot_in    = dll_pkg::slot_t'(32'(handle) + 32'd1);
    assign new_slot   = dll_pkg::slot_t'(next_free_reg);
    assign full       = 32'(next_free_reg) >= 32'(dll_pkg::SLOT_COUNT);
    assign bad_handle = (handle == '0)
                     || (32'(handle) > 32'(dll_pkg::CAPACITY))
                     || (32'(handle) + 32'd1 >= 32'(next_free_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dll_pkg::S_IDLE;
            head_right_reg <= dll_pkg::TAIL_SLOT;
            tail_left_reg  <= dll_pkg::HEAD_SLOT;
            next_free_reg  <= dll_pkg::FILL_W'(2);
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_right_reg <= head_right_next;
            tail_left_reg  <= tail_left_next;
            next_free_reg  <= next_free_next;
            done_reg       <= fin;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        slot_reg  <= slot_next;
        value_reg <= value_next;
        k_reg     <= k_next;
        nx_reg    <= nx_next;
        if (fin)
        begin
            node_handle_reg <= fin_handle;
            node_value_reg  <= fin_value;
            at_end_reg      <= fin_end;
            status_reg      <= fin_status;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        slot_next       = slot_reg;
        value_next      = value_reg;
        k_next          = k_reg;
        nx_next         = nx_reg;
        head_right_next = head_right_reg;
        tail_left_next  = tail_left_reg;
        next_free_next  = next_free_reg;
        fin             = 1'b0;
        fin_handle      = '0;
        fin_value       = '0;
        fin_end         = 1'b0;
        fin_status      = dll_pkg::ST_OK;
        rd_addr         = slot_in;
        store_wr        = '0;

        unique case (state_reg)
            dll_pkg::S_IDLE:
            begin
                if (start)
                begin
                    mode_next  = mode;
                    slot_next  = slot_in;
                    value_next = value;
                    unique case (mode) inside
                        dll_pkg::MODE_PUSH_FRONT, dll_pkg::MODE_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                fin        = 1'b1;
                                fin_status = dll_pkg::ST_FULL;
                            end
                            else if (mode == dll_pkg::MODE_PUSH_FRONT)
                            begin
                                k_next     = dll_pkg::HEAD_SLOT;
                                nx_next    = head_right_reg;
                                state_next = dll_pkg::S_WR_NEW;
                            end
                            else
                            begin
                                k_next     = tail_left_reg;
                                nx_next    = dll_pkg::TAIL_SLOT;
                                state_next = dll_pkg::S_WR_NEW;
                            end
                        end
                        dll_pkg::MODE_DELETE, dll_pkg::MODE_INS_LEFT,
                        dll_pkg::MODE_INS_RIGHT, dll_pkg::MODE_WALK:
                        begin
                            if (mode == dll_pkg::MODE_WALK && handle == '0)
                            begin
                                // walk from the head: its link lives in a register
                                if (walk_stop(head_right_reg))
                                begin
                                    fin     = 1'b1;
                                    fin_end = 1'b1;
                                end
                                else
                                begin
                                    rd_addr    = head_right_reg;
                                    nx_next    = head_right_reg;
                                    state_next = dll_pkg::S_VALUE;
                                end
                            end
                            else if (bad_handle)
                            begin
                                fin        = 1'b1;
                                fin_status = dll_pkg::ST_UNASSIGNED;
                            end
                            else
                            begin
                                state_next = dll_pkg::S_LOOK;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            dll_pkg::S_LOOK:
            begin
                if (!store_rd.live)
                begin
                    fin        = 1'b1;
                    fin_status = dll_pkg::ST_DELETED;
                end
                else
                begin
                    unique case (mode_reg) inside
                        dll_pkg::MODE_DELETE:
                        begin
                            // unlink: neighbors point past the node
                            if (store_rd.left == dll_pkg::HEAD_SLOT)
                            begin
                                head_right_next = store_rd.right;
                            end
                            else
                            begin
                                store_wr.right_we   = 1'b1;
                                store_wr.right_addr = store_rd.left;
                                store_wr.right_data = store_rd.right;
                            end
                            if (store_rd.right == dll_pkg::TAIL_SLOT)
                            begin
                                tail_left_next = store_rd.left;
                            end
                            else
                            begin
                                store_wr.left_we   = 1'b1;
                                store_wr.left_addr = store_rd.right;
                                store_wr.left_data = store_rd.left;
                            end
                            store_wr.live_we   = 1'b1;
                            store_wr.live_addr = slot_reg;
                            store_wr.live_data = 1'b0;
                            fin                = 1'b1;
                        end
                        dll_pkg::MODE_WALK:
                        begin
                            if (walk_stop(store_rd.right))
                            begin
                                fin     = 1'b1;
                                fin_end = 1'b1;
                            end
                            else
                            begin
                                rd_addr    = store_rd.right;
                                nx_next    = store_rd.right;
                                state_next = dll_pkg::S_VALUE;
                            end
                        end
                        dll_pkg::MODE_INS_LEFT, dll_pkg::MODE_INS_RIGHT:
                        begin
                            if (full)
                            begin
                                fin        = 1'b1;
                                fin_status = dll_pkg::ST_FULL;
                            end
                            else if (mode_reg == dll_pkg::MODE_INS_LEFT)
                            begin
                                // right link of the left neighbor is this node
                                k_next     = store_rd.left;
                                nx_next    = slot_reg;
                                state_next = dll_pkg::S_WR_NEW;
                            end
                            else
                            begin
                                k_next     = slot_reg;
                                nx_next    = store_rd.right;
                                state_next = dll_pkg::S_WR_NEW;
                            end
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            dll_pkg::S_WR_NEW:
            begin
                store_wr.value_we   = 1'b1;
                store_wr.value_addr = new_slot;
                store_wr.value_data = value_reg;
                store_wr.left_we    = 1'b1;
                store_wr.left_addr  = new_slot;
                store_wr.left_data  = k_reg;
                store_wr.right_we   = 1'b1;
                store_wr.right_addr = new_slot;
                store_wr.right_data = nx_reg;
                store_wr.live_we    = 1'b1;
                store_wr.live_addr  = new_slot;
                store_wr.live_data  = 1'b1;
                state_next          = dll_pkg::S_WR_LINK;
            end

            dll_pkg::S_WR_LINK:
            begin
                if (k_reg == dll_pkg::HEAD_SLOT)
                begin
                    head_right_next = new_slot;
                end
                else
                begin
                    store_wr.right_we   = 1'b1;
                    store_wr.right_addr = k_reg;
                    store_wr.right_data = new_slot;
                end
                if (nx_reg == dll_pkg::TAIL_SLOT)
                begin
                    tail_left_next = new_slot;
                end
                else
                begin
                    store_wr.left_we   = 1'b1;
                    store_wr.left_addr = nx_reg;
                    store_wr.left_data = new_slot;
                end
                next_free_next = next_free_reg + dll_pkg::FILL_W'(1);
                fin            = 1'b1;
                fin_handle     = dll_pkg::HANDLE_W'(32'(next_free_reg) - 32'd1);
            end

            dll_pkg::S_VALUE:
            begin
                fin        = 1'b1;
                fin_handle = dll_pkg::HANDLE_W'(32'(nx_reg) - 32'd1);
                fin_value  = store_rd.value;
            end

            default:
            begin
                state_next = dll_pkg::S_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next = dll_pkg::S_IDLE;
        end
    end

    assign busy        = (state_reg != dll_pkg::S_IDLE);
    assign done        = done_reg;
    assign node_handle = node_handle_reg;
    assign node_value  = node_value_reg;
    assign at_end      = at_end_reg;
    assign status      = status_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/doubly_linked_list_engine.sv =====
// Channel  | Handshake        | Payload                                  | Dir
// ---------+------------------+------------------------------------------+----
// command  | start / busy     | mode[2:0], handle[10:0], value[31:0] s   | in
// result   | done (1 cycle)   | node_handle[10:0], node_value[31:0] s,   | out
//          |                  | at_end, status[1:0]                      |
//
// An item is taken when start is high and busy is low; busy stays high while
// the item works. Items answered at the check (bad handle, full store on
// push, walk from the head of an empty list, unused modes) end in idle;
// delete, a deleted handle, a walk stopping at the tail and insert left/right
// on a full store end in look; a walk from the head to a node ends in value,
// from a handle in look then value; push front/back goes new-node write then
// link write, insert left/right look, new-node write, link write. The node
// store's single write port per field sets the two write passes of an insert.
// done marks the result for exactly one cycle; the outputs hold it until the
// next result. The receiver cannot stall; a new item may start in that cycle.
// rst_n is asynchronous: the list is empty after reset, no clearing pass.
`default_nettype none

module doubly_linked_list_engine (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [2:0]                         mode,
    input  wire logic [dll_pkg::HANDLE_W-1:0]       handle,
    input  wire logic signed [dll_pkg::VALUE_W-1:0] value,
    output logic                                    done,
    output logic [dll_pkg::HANDLE_W-1:0]            node_handle,
    output logic signed [dll_pkg::VALUE_W-1:0]      node_value,
    output logic                                    at_end,
    output logic [1:0]                              status
);

    // Store holds value, both links and a live mark per slot. The head's
    // right link and the tail's left link sit in the sequencer as registers,
    // so slots at or above the fill count are never used and need no reset.
    dll_pkg::store_wr_t store_wr;
    dll_pkg::store_rd_t store_rd;
    dll_pkg::slot_t     rd_addr;

    dll_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .handle      (handle),
        .value       (value),
        .done        (done),
        .node_handle (node_handle),
        .node_value  (node_value),
        .at_end      (at_end),
        .status      (status),
        .store_wr    (store_wr),
        .rd_addr     (rd_addr),
        .store_rd    (store_rd)
    );

    // Reads are issued only from the idle state or the look stage, after all
    // writes of the previous item are done, so no forwarding is needed.
    dll_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_addr (rd_addr),
        .rd_data (store_rd)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/dll_checker.sv =====
`default_nettype none
`include "doubly_linked_list_engine_defines.svh"

module dll_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        done,
    input  wire logic [10:0] node_handle,
    input  wire logic [31:0] node_value,
    input  wire logic        at_end,
    input  wire logic [1:0]  status
);

    // an accepted item either keeps the block busy or answers at once
    `DLLE_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done)
    // a result never shows while an item is still in work
    `DLLE_ASSERT_SAME(a_done_idle, done, !busy)
    // walk end carries no node
    `DLLE_ASSERT_SAME(a_end_empty, done && at_end,
        node_handle == 11'd0 && node_value == 32'd0 && status == dll_pkg::ST_OK)
    // failed items hand back no node
    `DLLE_ASSERT_SAME(a_fail_empty, done && status != dll_pkg::ST_OK,
        node_handle == 11'd0 && !at_end)

endmodule

bind doubly_linked_list_engine dll_checker u_dll_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .node_handle (node_handle),
    .node_value  (node_value),
    .at_end      (at_end),
    .status      (status)
);

`default_nettype wire

// ===== tb/dll_engine_checker.sv =====
// Result checker for doubly_linked_list_engine.
// Keeps its own copy of the list, works out each item's result when the item
// is taken, and compares it with what comes out on done.
module dll_engine_checker
    import dll_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic [2:0]                mode,
    input  logic [HANDLE_W-1:0]       handle,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      done,
    input  logic [HANDLE_W-1:0]       node_handle,
    input  logic signed [VALUE_W-1:0] node_value,
    input  logic                      at_end,
    input  logic [1:0]                status,
    output int                        fail_count,
    output int                        outstanding
);

    typedef struct packed {
        logic [HANDLE_W-1:0] node_handle;
        logic [VALUE_W-1:0]  node_value;
        logic                at_end;
        status_t             status;
    } list_result_t;

    // Mirror of the node store
    logic [VALUE_W-1:0] slot_value [SLOT_COUNT];
    slot_t              left_link  [SLOT_COUNT];
    slot_t              right_link [SLOT_COUNT];
    logic               slot_live  [SLOT_COUNT];
    slot_t              fresh_slot;

    list_result_t pending_results [$];

    // Maps a handle to its slot; anything but ST_OK leaves the list alone.
    function automatic status_t find_slot(input logic [HANDLE_W-1:0] h, output slot_t s);
        slot_t cand;
        s = HEAD_SLOT;
        if (h == 0 || h > CAPACITY)
            return ST_UNASSIGNED;
        cand = slot_t'(h) + slot_t'(1);
        if (cand >= fresh_slot)
            return ST_UNASSIGNED;
        if (!slot_live[cand])
            return ST_DELETED;
        s = cand;
        return ST_OK;
    endfunction

    // New node right of slot k; slots are handed out in order, never reused.
    function automatic list_result_t link_after(input slot_t k, input logic [VALUE_W-1:0] v);
        list_result_t r;
        slot_t        n;
        slot_t        nx;
        r = '0;
        if (fresh_slot >= SLOT_COUNT) begin
            r.status = ST_FULL;
            return r;
        end
        n  = fresh_slot;
        nx = right_link[k];
        slot_value[n]  = v;
        left_link[n]   = k;
        right_link[n]  = nx;
        left_link[nx]  = n;
        right_link[k]  = n;
        slot_live[n]   = 1'b1;
        fresh_slot     = n + slot_t'(1);
        r.node_handle  = HANDLE_W'(n - slot_t'(1));
        r.status       = ST_OK;
        return r;
    endfunction

    function automatic list_result_t list_op(input logic [2:0] op,
                                             input logic [HANDLE_W-1:0] h,
                                             input logic [VALUE_W-1:0] v);
        list_result_t r;
        slot_t        s;
        slot_t        nx;
        status_t      st;
        r = '0;
        case (op)
            MODE_PUSH_FRONT: r = link_after(HEAD_SLOT, v);
            MODE_PUSH_BACK:  r = link_after(left_link[TAIL_SLOT], v);
            MODE_DELETE:
            begin
                st = find_slot(h, s);
                r.status = st;
                if (st == ST_OK) begin
                    right_link[left_link[s]] = right_link[s];
                    left_link[right_link[s]] = left_link[s];
                    slot_live[s] = 1'b0;
                end
            end
            MODE_INS_LEFT, MODE_INS_RIGHT:
            begin
                // handle is checked before room
                st = find_slot(h, s);
                if (st != ST_OK)
                    r.status = st;
                else if (op == MODE_INS_LEFT)
                    r = link_after(left_link[s], v);
                else
                    r = link_after(s, v);
            end
            MODE_WALK:
            begin
                if (h == 0) begin
                    st = ST_OK;
                    s  = HEAD_SLOT;
                end else begin
                    st = find_slot(h, s);
                end
                r.status = st;
                if (st == ST_OK) begin
                    nx = right_link[s];
                    if (nx < FIRST_SLOT) begin
                        r.at_end = 1'b1;
                    end else begin
                        r.node_handle = HANDLE_W'(nx - slot_t'(1));
                        r.node_value  = slot_value[nx];
                    end
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // Outputs are read before this edge's updates land: done first, then the
    // newly taken item, so a result and a take in one cycle stay in order.
    always @(posedge clk) begin
        list_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                left_link[i]  = HEAD_SLOT;
                right_link[i] = HEAD_SLOT;
                slot_live[i]  = 1'b0;
            end
            right_link[HEAD_SLOT] = TAIL_SLOT;
            left_link[TAIL_SLOT]  = HEAD_SLOT;
            fresh_slot = FIRST_SLOT;
            pending_results.delete();
        end else begin
            if (done === 1'b1) begin
                if (pending_results.size() == 0) begin
                    $error("result with no item pending: node_handle %0d status %0d",
                           node_handle, status);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (node_handle !== want.node_handle) begin
                        $error("node_handle: expected %0d, got %0d",
                               want.node_handle, node_handle);
                        fail_count++;
                    end
                    if (node_value !== want.node_value) begin
                        $error("node_value: expected %0d, got %0d",
                               $signed(want.node_value), node_value);
                        fail_count++;
                    end
                    if (at_end !== want.at_end) begin
                        $error("at_end: expected %0d, got %0d", want.at_end, at_end);
                        fail_count++;
                    end
                    if (status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                pending_results.push_back(list_op(mode, handle, value));
        end
        outstanding = pending_results.size();
    end

endmodule

// ===== tb/tb_doubly_linked_list_engine.sv =====
// Testbench top: makes the command stream, hands checking to the checker
// module beside the DUT, and gives the verdict.
module tb_doubly_linked_list_engine;
    import dll_pkg::*;

    localparam int ITEM_TARGET = 1950;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_ITEMS  = 120;      // rough item count of the closing steps

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [2:0]                mode;
    logic [HANDLE_W-1:0]       handle;
    logic signed [VALUE_W-1:0] value;
    logic                      done;
    logic [HANDLE_W-1:0]       node_handle;
    logic signed [VALUE_W-1:0] node_value;
    logic                      at_end;
    logic [1:0]                status;

    int fail_count;
    int outstanding;
    int items_sent;
    int idle_pct;       // chance, in percent, of a gap cycle before an item
    int top_handle;     // highest handle seen on the result side so far
    int cycle_count;

    doubly_linked_list_engine DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .handle      (handle),
        .value       (value),
        .done        (done),
        .node_handle (node_handle),
        .node_value  (node_value),
        .at_end      (at_end),
        .status      (status)
    );

    dll_engine_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .handle      (handle),
        .value       (value),
        .done        (done),
        .node_handle (node_handle),
        .node_value  (node_value),
        .at_end      (at_end),
        .status      (status),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Handles come out in insert order, so the largest one seen tells which
    // handles have been given out; it steers the choice of targets.
    always @(posedge clk) begin
        if (done === 1'b1 && int'(node_handle) > top_handle)
            top_handle = int'(node_handle);
    end

    // Watchdog: a hung handshake or a lost result ends here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Entered and left at a falling edge. Optional gap with start low, then
    // the item is held until an edge sees busy low. start stays high when
    // items follow back to back, so it gets one assignment per step.
    task automatic send_item(input logic [2:0] m, input logic [HANDLE_W-1:0] h,
                             input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start  <= 1'b1;
        mode   <= m;
        handle <= h;
        value  <= v;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Mostly handles already given out (live or deleted), plus zero, the
    // next unassigned one, and anything in the 11-bit range.
    function automatic logic [HANDLE_W-1:0] pick_handle();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return HANDLE_W'($urandom_range(top_handle > 0 ? top_handle : 1, 1));
        else if (r < 86)
            return '0;
        else if (r < 90)
            return HANDLE_W'(top_handle + 1);
        return HANDLE_W'($urandom_range(2047, 0));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Follows the list from a start point using each returned handle, the
    // way a host would print it; stops at the tail or on a bad status.
    // start drops while the answer is awaited so the step is taken once.
    task automatic walk_chain(input logic [HANDLE_W-1:0] from, input int steps);
        logic [HANDLE_W-1:0] cur;
        logic                stop;
        cur  = from;
        stop = 1'b0;
        for (int i = 0; i < steps && !stop; i++) begin
            send_item(MODE_WALK, cur, $urandom);
            start <= 1'b0;
            @(posedge clk);
            while (done !== 1'b1)
                @(posedge clk);
            stop = at_end || (status != ST_OK);
            cur  = node_handle;
            @(negedge clk);
        end
    endtask

    // One random step: inserts outweigh deletes so the store fills up
    // partway through, and the rest of the run works against a full store.
    task automatic random_step();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            send_item(MODE_PUSH_FRONT, HANDLE_W'($urandom), pick_value());
        else if (r < 35)
            send_item(MODE_PUSH_BACK, HANDLE_W'($urandom), pick_value());
        else if (r < 48)
            send_item(MODE_INS_LEFT, pick_handle(), pick_value());
        else if (r < 60)
            send_item(MODE_INS_RIGHT, pick_handle(), pick_value());
        else if (r < 75)
            send_item(MODE_DELETE, pick_handle(), pick_value());
        else if (r < 88)
            walk_chain($urandom_range(1) ? HANDLE_W'(0) : pick_handle(),
                       $urandom_range(10, 1));
        else
            // noise: any mode including the unused ones, any handle
            send_item(3'($urandom_range(7)), HANDLE_W'($urandom_range(2047)), $urandom);
    endtask

    initial begin
        rst_n      = 1'b0;
        start      = 1'b0;
        mode       = '0;
        handle     = '0;
        value      = '0;
        items_sent = 0;
        idle_pct   = 17;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----
        // empty list: walk from head ends at once; no handle is valid yet
        send_item(MODE_WALK, 11'd0, 32'h1234_5678);
        send_item(MODE_DELETE, 11'd0, '0);
        send_item(MODE_DELETE, 11'd1, '0);
        send_item(MODE_INS_LEFT, 11'd2047, 32'h5555_aaaa);
        send_item(MODE_INS_RIGHT, 11'd1025, 32'haaaa_5555);
        send_item(MODE_WALK, 11'd1024, '0);
        // build: h3 h4 h1 h2 h5
        send_item(MODE_PUSH_FRONT, '0, 32'h7fff_ffff);      // h1
        send_item(MODE_PUSH_BACK, 11'h7ff, 32'h8000_0000);  // h2
        send_item(MODE_PUSH_FRONT, '0, 32'hffff_ffff);      // h3
        send_item(MODE_INS_LEFT, 11'd1, 32'h0000_0000);     // h4
        send_item(MODE_INS_RIGHT, 11'd2, 32'h0000_0001);    // h5
        send_item(MODE_WALK, 11'd0, '0);
        send_item(MODE_WALK, 11'd4, '0);
        send_item(MODE_WALK, 11'd5, '0);                    // tail reached
        send_item(MODE_DELETE, 11'd7, '0);                  // not given out yet
        // delete, then every operation on the deleted node
        send_item(MODE_DELETE, 11'd1, '0);
        send_item(MODE_DELETE, 11'd1, '0);
        send_item(MODE_WALK, 11'd1, '0);
        send_item(MODE_INS_LEFT, 11'd1, 32'h0bad_0bad);
        send_item(MODE_INS_RIGHT, 11'd1, 32'h0bad_0bad);
        // unlink at both ends
        send_item(MODE_DELETE, 11'd5, '0);
        send_item(MODE_DELETE, 11'd3, '0);
        send_item(MODE_WALK, 11'd0, '0);
        send_item(MODE_INS_RIGHT, 11'd2, 32'hdead_beef);    // h6 at the back
        // unused modes
        send_item(3'd6, 11'h7ff, 32'hffff_ffff);
        send_item(3'd7, 11'd1, 32'h0000_0001);

        // ---- random part, three idle phases ----
        // leaves room in the item budget for the fill and the closing steps
        while (items_sent + (CAPACITY - top_handle) < ITEM_TARGET - TAIL_ITEMS) begin
            if (items_sent < ITEM_TARGET / 3)
                idle_pct = 17;
            else if (items_sent < 2 * ITEM_TARGET / 3)
                idle_pct = 46;
            else
                idle_pct = 0;
            random_step();
        end
        idle_pct = 0;
        // make sure the store-full path is reached, then keep going on it
        while (top_handle < CAPACITY)
            send_item(MODE_PUSH_BACK, '0, pick_value());
        for (int i = 0; i < 80; i++)
            random_step();
        start <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dll_pkg.sv
hw/rtl/dll_store.sv
hw/rtl/dll_ctrl.sv
hw/rtl/doubly_linked_list_engine.sv
hw/rtl/dll_checker.sv
tb/dll_engine_checker.sv
tb/tb_doubly_linked_list_engine.sv
